// File: rtl/iba_pkg.sv
package iba_pkg;

  localparam int IBA_DEPTH       = 32;
  localparam int IBA_COORD_BITS  = 12;
  localparam int IBA_THR_BITS    = 17;
  localparam int IBA_PROB_BITS   = 16;
  localparam int IBA_CLASS_BITS  = 8;
  localparam int IBA_HITS_BITS   = 16;
  localparam int IBA_INDEX_BITS  = 5;
  localparam int IBA_FRAC_BITS   = 16;

  localparam logic [IBA_THR_BITS-1:0] IBA_THR_RESET = 17'd32768;

  localparam logic OP_BOX  = 1'b0;
  localparam logic OP_DUMP = 1'b1;

  localparam logic KIND_BOX   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  typedef struct packed {
    logic s0;
    logic s1;
  } eval_ctl_t;

endpackage

// File: rtl/iba_req_if.sv
interface iba_req_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [7:0]            box_class;
  logic [15:0]           probability;
  logic [COORD_BITS-1:0] box_xmin;
  logic [COORD_BITS-1:0] box_ymin;
  logic [COORD_BITS-1:0] box_xmax;
  logic [COORD_BITS-1:0] box_ymax;

  modport source (output valid, op, box_class, probability, box_xmin, box_ymin, box_xmax,
                  box_ymax, input ready);
  modport sink (input valid, op, box_class, probability, box_xmin, box_ymin, box_xmax,
                box_ymax, output ready);
endinterface

// File: rtl/iba_res_if.sv
interface iba_res_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic                  entry_valid;
  logic                  is_new;
  logic                  table_full;
  logic [4:0]            out_index;
  logic [7:0]            out_class;
  logic [15:0]           out_confidence;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [COORD_BITS-1:0] out_w;
  logic [COORD_BITS-1:0] out_h;
  logic                  last;

  modport source (output valid, kind, entry_valid, is_new, table_full, out_index, out_class,
                  out_confidence, out_x, out_y, out_w, out_h, last, input ready);
  modport sink (input valid, kind, entry_valid, is_new, table_full, out_index, out_class,
                out_confidence, out_x, out_y, out_w, out_h, last, output ready);
endinterface

// File: rtl/iba_cfg_if.sv
interface iba_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] iou_threshold;

  modport source (output valid, iou_threshold, input ready);
  modport sink (input valid, iou_threshold, output ready);
endinterface

// File: rtl/iba_cell.sv
module iba_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic         d_valid,
  input  logic [W-1:0] d_data,
  output logic         q_valid,
  output logic [W-1:0] q_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (shift) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      q_data <= d_data;
    end
  end

endmodule

// File: rtl/iba_eval.sv
module iba_eval
  import iba_pkg::*;
#(
  parameter int COORD_BITS = IBA_COORD_BITS
) (
  input  logic                    clk,
  input  eval_ctl_t               ctl,
  input  logic                    eligible,
  input  logic [COORD_BITS-1:0]   ex,
  input  logic [COORD_BITS-1:0]   ey,
  input  logic [COORD_BITS-1:0]   ew,
  input  logic [COORD_BITS-1:0]   eh,
  input  logic [COORD_BITS-1:0]   bx,
  input  logic [COORD_BITS-1:0]   by,
  input  logic [COORD_BITS-1:0]   bw,
  input  logic [COORD_BITS-1:0]   bh,
  input  logic [IBA_THR_BITS-1:0] thr,
  output logic                    hit
);

  localparam int C  = COORD_BITS;
  localparam int A  = 2 * C;
  localparam int CW = A + IBA_FRAC_BITS + 2;

  logic [C:0]   ex_end, bx_end, x_hi, x_lo, x_ext, x_sum;
  logic [C:0]   ey_end, by_end, y_hi, y_lo, y_ext, y_sum;
  logic [C-1:0] iw_next, ih_next;
  logic [C-1:0] iw, ih;
  logic         elig0, elig1;
  logic [A-1:0] inter, earea, barea;
  logic [A:0]   uni;
  logic [CW-1:0] lhs, rhs;

  // overlap per axis: w1 + w2 - (max end - min start)
  always_comb begin
    ex_end  = {1'b0, ex} + {1'b0, ew};
    bx_end  = {1'b0, bx} + {1'b0, bw};
    x_hi    = (ex_end > bx_end) ? ex_end : bx_end;
    x_lo    = (ex < bx) ? {1'b0, ex} : {1'b0, bx};
    x_ext   = x_hi - x_lo;
    x_sum   = {1'b0, ew} + {1'b0, bw};
    iw_next = (x_sum > x_ext) ? C'(x_sum - x_ext) : '0;
    ey_end  = {1'b0, ey} + {1'b0, eh};
    by_end  = {1'b0, by} + {1'b0, bh};
    y_hi    = (ey_end > by_end) ? ey_end : by_end;
    y_lo    = (ey < by) ? {1'b0, ey} : {1'b0, by};
    y_ext   = y_hi - y_lo;
    y_sum   = {1'b0, eh} + {1'b0, bh};
    ih_next = (y_sum > y_ext) ? C'(y_sum - y_ext) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.s0) begin
      iw    <= iw_next;
      ih    <= ih_next;
      elig0 <= eligible;
    end
    if (ctl.s1) begin
      inter <= iw * ih;
      earea <= ew * eh;
      barea <= bw * bh;
      elig1 <= elig0;
    end
  end

  // cross-multiplied test: inter * 2^16 > thr * union
  always_comb begin
    uni = {1'b0, earea} + {1'b0, barea} - {1'b0, inter};
    lhs = {2'b00, inter, {IBA_FRAC_BITS{1'b0}}};
    rhs = CW'(thr) * CW'(uni);
    hit = elig1 && (lhs > rhs);
  end

endmodule

// File: rtl/iou_box_association_table.sv
// IoU box association table. Each request is either a detection box or a dump.
// A box is checked against every table entry in index order, through states
// S_P0, S_P1 and S_P2 for each entry in one overlap / multiply / compare unit fed
// from the head of a rotating ring of entry cells; when the box is inserted as a
// new entry the ring rotates once more in S_INS, and its single result is then
// loaded and handed off from S_OUT. A dump rotates the ring once, one entry per
// cycle when the output is free, emitting TABLE_DEPTH results with last on the
// final one and clearing every entry. The threshold register is written through
// the cfg channel, which is always ready; write it only while the block is idle.
module iou_box_association_table
  import iba_pkg::*;
#(
  parameter int TABLE_DEPTH = IBA_DEPTH,
  parameter int COORD_BITS  = IBA_COORD_BITS
) (
  input logic         clk,
  input logic         rst,
  iba_req_if.sink     box_in,
  iba_res_if.source   res_out,
  iba_cfg_if.sink     cfg
);

  localparam int C  = COORD_BITS;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int DW = IBA_CLASS_BITS + IBA_PROB_BITS + 4 * C + IBA_HITS_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P0   = 3'd1;
  localparam logic [2:0] S_P1   = 3'd2;
  localparam logic [2:0] S_P2   = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_DUMP = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state;
  logic [IW-1:0] idx;
  logic [IBA_THR_BITS-1:0] thr;

  logic [IBA_CLASS_BITS-1:0] b_cls;
  logic [IBA_PROB_BITS-1:0]  b_prob;
  logic [C-1:0] b_x, b_y, b_w, b_h;

  logic found, free_found;
  logic [IW-1:0] first_idx, free_idx;

  logic          cell_v [TABLE_DEPTH];
  logic [DW-1:0] cell_d [TABLE_DEPTH];
  logic          shift;
  logic          head_v, head_v_next;
  logic [DW-1:0] head_d, head_d_next;

  logic [IBA_CLASS_BITS-1:0] h_cls;
  logic [IBA_PROB_BITS-1:0]  h_conf;
  logic [C-1:0]              h_x, h_y, h_w, h_h;
  logic [IBA_HITS_BITS-1:0]  h_hits, h_hits_inc;

  eval_ctl_t ctl;
  logic      hit, upd, out_free;

  assign cfg.ready    = 1'b1;
  assign box_in.ready = (state == S_IDLE);
  assign out_free     = !res_out.valid || res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= IBA_THR_RESET;
    end else if (cfg.valid) begin
      thr <= cfg.iou_threshold;
    end
  end

  assign head_v = cell_v[TABLE_DEPTH-1];
  assign head_d = cell_d[TABLE_DEPTH-1];
  assign {h_cls, h_conf, h_x, h_y, h_w, h_h, h_hits} = head_d;
  assign h_hits_inc = (h_hits == '1) ? h_hits : h_hits + 1'b1;

  generate
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_ring
      if (k == 0) begin : g_first
        iba_cell #(.W(DW)) u_cell (
          .clk(clk), .rst(rst), .shift(shift),
          .d_valid(head_v_next), .d_data(head_d_next),
          .q_valid(cell_v[k]), .q_data(cell_d[k])
        );
      end else begin : g_rest
        iba_cell #(.W(DW)) u_cell (
          .clk(clk), .rst(rst), .shift(shift),
          .d_valid(cell_v[k-1]), .d_data(cell_d[k-1]),
          .q_valid(cell_v[k]), .q_data(cell_d[k])
        );
      end
    end
  endgenerate

  assign ctl.s0 = (state == S_P0);
  assign ctl.s1 = (state == S_P1);

  iba_eval #(.COORD_BITS(C)) u_eval (
    .clk(clk), .ctl(ctl),
    .eligible(head_v && (h_cls == b_cls)),
    .ex(h_x), .ey(h_y), .ew(h_w), .eh(h_h),
    .bx(b_x), .by(b_y), .bw(b_w), .bh(b_h),
    .thr(thr), .hit(hit)
  );

  assign upd = hit && (b_prob > h_conf);

  always_comb begin
    shift       = 1'b0;
    head_v_next = head_v;
    head_d_next = head_d;
    case (state)
      S_P2: begin
        shift = 1'b1;
        if (upd) begin
          head_d_next = {h_cls, b_prob, b_x, b_y, b_w, b_h, h_hits_inc};
        end
      end
      S_INS: begin
        shift = 1'b1;
        if (idx == free_idx) begin
          head_v_next = 1'b1;
          head_d_next = {b_cls, b_prob, b_x, b_y, b_w, b_h, {IBA_HITS_BITS{1'b0}}};
        end
      end
      S_DUMP: begin
        shift       = out_free;
        head_v_next = 1'b0;
      end
      default: begin
        shift = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      found         <= 1'b0;
      free_found    <= 1'b0;
      res_out.valid <= 1'b0;
    end else begin
      if (out_free && (state == S_DUMP || state == S_OUT)) begin
        res_out.valid <= 1'b1;
      end else if (res_out.ready) begin
        res_out.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (box_in.valid) begin
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= (box_in.op == OP_DUMP) ? S_DUMP : S_P0;
          end
        end
        S_P0: state <= S_P1;
        S_P1: state <= S_P2;
        S_P2: begin
          idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
          if (hit && !found) begin
            found     <= 1'b1;
            first_idx <= idx;
          end
          if (!head_v && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx == LAST_IDX) begin
            if (!found && !hit && (free_found || !head_v)) begin
              state <= S_INS;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_P0;
          end
        end
        S_INS: begin
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= S_OUT;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            idx <= idx + 1'b1;
            if (idx == LAST_IDX) begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // box capture
  always_ff @(posedge clk) begin
    if (box_in.valid && box_in.ready) begin
      b_cls  <= box_in.box_class;
      b_prob <= box_in.probability;
      b_x    <= box_in.box_xmin;
      b_y    <= box_in.box_ymin;
      b_w    <= (box_in.box_xmax >= box_in.box_xmin) ? box_in.box_xmax - box_in.box_xmin : '0;
      b_h    <= (box_in.box_ymax >= box_in.box_ymin) ? box_in.box_ymax - box_in.box_ymin : '0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_DUMP && out_free) begin
      res_out.kind        <= KIND_ENTRY;
      res_out.entry_valid <= head_v;
      res_out.is_new      <= 1'b0;
      res_out.table_full  <= 1'b0;
      res_out.out_index   <= 5'(idx);
      res_out.out_class   <= head_v ? h_cls : '0;
      res_out.out_confidence <= head_v ? h_conf : '0;
      res_out.out_x       <= head_v ? h_x : '0;
      res_out.out_y       <= head_v ? h_y : '0;
      res_out.out_w       <= head_v ? h_w : '0;
      res_out.out_h       <= head_v ? h_h : '0;
      res_out.last        <= (idx == LAST_IDX);
    end else if (state == S_OUT && out_free) begin
      res_out.kind        <= KIND_BOX;
      res_out.entry_valid <= found || free_found;
      res_out.is_new      <= !found && free_found;
      res_out.table_full  <= !found && !free_found;
      res_out.out_index   <= found ? 5'(first_idx) : (free_found ? 5'(free_idx) : 5'd0);
      res_out.out_class   <= '0;
      res_out.out_confidence <= '0;
      res_out.out_x       <= '0;
      res_out.out_y       <= '0;
      res_out.out_w       <= '0;
      res_out.out_h       <= '0;
      res_out.last        <= 1'b1;
    end
  end

endmodule

// File: tb/sv/tb_iba_checker.sv
`timescale 1ns / 1ps

module tb_iba_checker
  import iba_pkg::*;
(
  input logic   clk,
  input logic   rst,
  iba_req_if    box_in,
  iba_res_if    res_out,
  iba_cfg_if    cfg,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    logic        kind;
    logic        entry_valid;
    logic        is_new;
    logic        table_full;
    logic [4:0]  out_index;
    logic [7:0]  out_class;
    logic [15:0] out_confidence;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [11:0] out_w;
    logic [11:0] out_h;
    logic        last;
  } assoc_result_t;

  assoc_result_t result_fifo[$];

  logic [16:0] threshold;
  logic        slot_used[IBA_DEPTH];
  logic [7:0]  slot_class[IBA_DEPTH];
  logic [15:0] slot_conf[IBA_DEPTH];
  logic [11:0] slot_x[IBA_DEPTH];
  logic [11:0] slot_y[IBA_DEPTH];
  logic [11:0] slot_w[IBA_DEPTH];
  logic [11:0] slot_h[IBA_DEPTH];
  logic [15:0] slot_hits[IBA_DEPTH];

  function automatic longint unsigned axis_overlap(longint unsigned a, longint unsigned aw,
                                                   longint unsigned b, longint unsigned bw);
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned ext;
    hi = (a + aw > b + bw) ? a + aw : b + bw;
    lo = (a < b) ? a : b;
    ext = hi - lo;
    return (aw + bw > ext) ? aw + bw - ext : 0;
  endfunction

  function automatic bit iou_over(int i, longint unsigned x, longint unsigned y,
                                  longint unsigned w, longint unsigned h);
    longint unsigned iw;
    longint unsigned ih;
    longint unsigned inter;
    longint unsigned uni;
    iw = axis_overlap(slot_x[i], slot_w[i], x, w);
    ih = axis_overlap(slot_y[i], slot_h[i], y, h);
    if (iw == 0 || ih == 0) return 0;
    inter = iw * ih;
    uni = longint'(slot_w[i]) * slot_h[i] + w * h - inter;
    return (inter << 16) > longint'(threshold) * uni;
  endfunction

  task automatic predict_request();
    assoc_result_t r;
    logic [11:0] w;
    logic [11:0] h;
    int first;
    int free_slot;
    if (box_in.op == OP_DUMP) begin
      for (int i = 0; i < IBA_DEPTH; i++) begin
        r = '0;
        r.kind = KIND_ENTRY;
        r.out_index = i[4:0];
        if (slot_used[i]) begin
          r.entry_valid = 1;
          r.out_class = slot_class[i];
          r.out_confidence = slot_conf[i];
          r.out_x = slot_x[i];
          r.out_y = slot_y[i];
          r.out_w = slot_w[i];
          r.out_h = slot_h[i];
        end
        r.last = (i == IBA_DEPTH - 1);
        slot_used[i] = 0;
        result_fifo = {result_fifo, r};
      end
      return;
    end
    w = (box_in.box_xmax >= box_in.box_xmin) ? box_in.box_xmax - box_in.box_xmin : '0;
    h = (box_in.box_ymax >= box_in.box_ymin) ? box_in.box_ymax - box_in.box_ymin : '0;
    first = -1;
    free_slot = -1;
    for (int i = 0; i < IBA_DEPTH; i++) begin
      if (slot_used[i] && slot_class[i] == box_in.box_class
          && iou_over(i, box_in.box_xmin, box_in.box_ymin, w, h)) begin
        if (first < 0) first = i;
        if (box_in.probability > slot_conf[i]) begin
          if (slot_hits[i] != 16'hFFFF) slot_hits[i]++;
          slot_conf[i] = box_in.probability;
          slot_x[i] = box_in.box_xmin;
          slot_y[i] = box_in.box_ymin;
          slot_w[i] = w;
          slot_h[i] = h;
        end
      end
    end
    r = '0;
    r.kind = KIND_BOX;
    r.last = 1;
    if (first >= 0) begin
      r.entry_valid = 1;
      r.out_index = first[4:0];
    end else begin
      for (int i = IBA_DEPTH - 1; i >= 0; i--)
        if (!slot_used[i]) free_slot = i;
      if (free_slot < 0) begin
        r.table_full = 1;
      end else begin
        slot_used[free_slot] = 1;
        slot_class[free_slot] = box_in.box_class;
        slot_conf[free_slot] = box_in.probability;
        slot_hits[free_slot] = '0;
        slot_x[free_slot] = box_in.box_xmin;
        slot_y[free_slot] = box_in.box_ymin;
        slot_w[free_slot] = w;
        slot_h[free_slot] = h;
        r.entry_valid = 1;
        r.is_new = 1;
        r.out_index = free_slot[4:0];
      end
    end
    result_fifo = {result_fifo, r};
  endtask

  task automatic compare_result();
    assoc_result_t got;
    assoc_result_t want;
    got = '{res_out.kind, res_out.entry_valid, res_out.is_new, res_out.table_full,
            res_out.out_index, res_out.out_class, res_out.out_confidence, res_out.out_x,
            res_out.out_y, res_out.out_w, res_out.out_h, res_out.last};
    if (result_fifo.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      fail_count++;
      return;
    end
    want = result_fifo.pop_front();
    if (got !== want) begin
      $display("%0t: result mismatch expected %h actual %h", $time, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold <= IBA_THR_RESET;
      for (int i = 0; i < IBA_DEPTH; i++) slot_used[i] = 0;
      result_fifo.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (res_out.valid && res_out.ready) compare_result();
      if (box_in.valid && box_in.ready) predict_request();
      if (cfg.valid && cfg.ready) threshold <= cfg.iou_threshold;
      pending = result_fifo.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb
  import iba_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   quiet_cycles;
  bit   gaps_on;

  iba_req_if box_in();
  iba_res_if res_out();
  iba_cfg_if cfg();

  iou_box_association_table DUT (
    .clk(clk), .rst(rst), .box_in(box_in), .res_out(res_out), .cfg(cfg)
  );

  tb_iba_checker checker_i (
    .clk(clk), .rst(rst), .box_in(box_in), .res_out(res_out), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // drain side stalls in bursts
  initial begin
    int stall;
    res_out.ready <= 0;
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        stall = int'($urandom_range(1, 7));
        res_out.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      res_out.ready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (box_in.valid && box_in.ready) || (res_out.valid && res_out.ready)
        || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // valid stays high into the next request; idle bursts and callers drop it
  task automatic send_request(logic op, logic [7:0] cls, logic [15:0] prob,
                              logic [11:0] x0, logic [11:0] y0, logic [11:0] x1,
                              logic [11:0] y1);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      box_in.valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    box_in.valid <= 1;
    box_in.op <= op;
    box_in.box_class <= cls;
    box_in.probability <= prob;
    box_in.box_xmin <= x0;
    box_in.box_ymin <= y0;
    box_in.box_xmax <= x1;
    box_in.box_ymax <= y1;
    do @(posedge clk); while (!box_in.ready);
  endtask

  task automatic send_box(logic [7:0] cls, logic [15:0] prob, logic [11:0] x0,
                          logic [11:0] y0, logic [11:0] x1, logic [11:0] y1);
    send_request(OP_BOX, cls, prob, x0, y0, x1, y1);
  endtask

  task automatic send_dump();
    send_request(OP_DUMP, 8'($urandom), 16'($urandom), 12'($urandom), 12'($urandom),
                 12'($urandom), 12'($urandom));
  endtask

  // hold until drained, then give a box still in flight time to finish
  task automatic write_threshold(logic [16:0] value);
    box_in.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg.valid <= 1;
    cfg.iou_threshold <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
  endtask

  // random box, its start often masked to coarse positions so matches actually happen
  task automatic random_box(logic [7:0] cls_max);
    logic [11:0] x0;
    logic [11:0] y0;
    logic [11:0] bw;
    logic [11:0] bh;
    if ($urandom_range(0, 9) == 0) begin
      send_box(8'($urandom), 16'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
               12'($urandom));
      return;
    end
    x0 = 12'($urandom_range(0, 3800));
    y0 = 12'($urandom_range(0, 3800));
    x0 = ($urandom_range(0, 1) == 0) ? (x0 & 12'h0C0) : x0;
    y0 = ($urandom_range(0, 1) == 0) ? (y0 & 12'h0C0) : y0;
    bw = 12'($urandom_range(1, 200));
    bh = 12'($urandom_range(1, 200));
    send_box(8'($urandom_range(0, cls_max)), 16'($urandom), x0, y0,
             12'(x0 + bw + $urandom_range(0, 4)), 12'(y0 + bh + $urandom_range(0, 4)));
  endtask

  initial begin
    logic [16:0] thr_set[5];
    thr_set = '{17'd0, 17'd65536, 17'd16384, 17'd45000, 17'h1FFFF};
    rst = 1;
    gaps_on = 1;
    box_in.valid <= 0;
    box_in.op <= OP_BOX;
    box_in.box_class <= '0;
    box_in.probability <= '0;
    box_in.box_xmin <= '0;
    box_in.box_ymin <= '0;
    box_in.box_xmax <= '0;
    box_in.box_ymax <= '0;
    cfg.valid <= 0;
    cfg.iou_threshold <= '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, match, update, zero area, reversed corners, dump, table full
    send_box(8'd0, 16'd100, 12'd0, 12'd0, 12'd100, 12'd100);
    send_box(8'd0, 16'd200, 12'd0, 12'd0, 12'd100, 12'd100);
    send_box(8'd0, 16'd50, 12'd2, 12'd2, 12'd101, 12'd101);
    send_box(8'd1, 16'd300, 12'd0, 12'd0, 12'd100, 12'd100);
    send_box(8'd255, 16'hFFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF);
    send_box(8'd255, 16'hFFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF);
    send_box(8'd0, 16'd0, 12'd50, 12'd50, 12'd50, 12'd90);
    send_box(8'd0, 16'd0, 12'd50, 12'd50, 12'd50, 12'd90);
    send_box(8'hAA, 16'h5555, 12'hFFF, 12'hFFF, 12'd0, 12'd0);
    send_box(8'h55, 16'hAAAA, 12'hAAA, 12'h555, 12'hFFE, 12'hFFE);
    send_dump();
    for (int i = 0; i < 34; i++)
      send_box(8'd7, 16'd10, 12'(i * 120), 12'd0, 12'(i * 120 + 100), 12'd100);
    send_box(8'd7, 16'd999, 12'd0, 12'd0, 12'd100, 12'd100);
    send_dump();
    send_dump();

    for (int p = 0; p < 5; p++) begin
      write_threshold(thr_set[p]);
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 24) == 0) send_dump();
        else random_box(p[0] ? 8'd3 : 8'd255);
      end
      send_dump();
    end

    write_threshold(IBA_THR_RESET);
    gaps_on = 0;
    for (int n = 0; n < 40; n++) random_box(8'd2);
    send_dump();
    box_in.valid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
